// ----- sv/radio_state_energy_meter_assert.svh -----
// Assertion macros shared by the checker of the radio state energy meter.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RADIO_STATE_ENERGY_METER_ASSERT_SVH
`define RADIO_STATE_ENERGY_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rsem_pkg.sv -----
// Package of the radio state energy meter: widths, codes, command types and
// the constant table of the nanojoule divider. No dependencies.
package rsem_pkg;

  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned CFG_W         = 29;
  localparam int unsigned VOLT_W        = 16;
  localparam int unsigned PWR_W         = 6;
  localparam int unsigned RSTATE_W      = 3;
  localparam int unsigned CUR_W         = 31;
  localparam int unsigned A_W           = CUR_W + VOLT_W;
  localparam int unsigned SLOPE_W       = 27;
  localparam int unsigned ACC_W         = 128;
  localparam int unsigned REM_W         = 30;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned NRG_W         = 64;
  localparam int unsigned LIMB_W        = 32;
  localparam int unsigned PP_STEPS      = 4;
  localparam int unsigned PP_IDX_W      = $clog2(PP_STEPS);
  localparam int unsigned DIV_STEPS     = ACC_W / DIGIT_W;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

  // Division by six as a multiply by the rounded-up reciprocal and a shift.
  localparam logic [31:0] DIV6_RECIP = 32'hAAAA_AAAB;
  localparam int unsigned DIV6_SHIFT = 34;

  // Transmit power clamp and anchor point, in dBm.
  localparam logic signed [PWR_W-1:0] PWR_MIN    = 6'sd2;
  localparam logic signed [PWR_W-1:0] PWR_MAX    = 6'sd20;
  localparam logic signed [PWR_W-1:0] PWR_ANCHOR = 6'sd14;

  // Multiples of one nanojoule in units of 1e-18 J, one per quotient digit.
  localparam logic [REM_W+DIGIT_W-1:0] NJ_MULT [2**DIGIT_W] = '{
    34'd0,           34'd1000000000,  34'd2000000000,  34'd3000000000,
    34'd4000000000,  34'd5000000000,  34'd6000000000,  34'd7000000000,
    34'd8000000000,  34'd9000000000,  34'd10000000000, 34'd11000000000,
    34'd12000000000, 34'd13000000000, 34'd14000000000, 34'd15000000000
  };

  // Radio state codes; the remaining codes are charged as idle.
  localparam logic [RSTATE_W-1:0] RS_IDLE  = 3'd0;
  localparam logic [RSTATE_W-1:0] RS_TX    = 3'd1;
  localparam logic [RSTATE_W-1:0] RS_RX    = 3'd2;
  localparam logic [RSTATE_W-1:0] RS_CAD   = 3'd3;
  localparam logic [RSTATE_W-1:0] RS_SLEEP = 3'd4;

  typedef enum logic [2:0] {
    REG_TX_FIXED   = 3'd0,
    REG_AUTO_TX    = 3'd1,
    REG_ANCHOR_LOW = 3'd2,
    REG_ANCHOR_HI  = 3'd3,
    REG_RX_CUR     = 3'd4,
    REG_CAD_CUR    = 3'd5,
    REG_IDLE_CUR   = 3'd6,
    REG_SLEEP_CUR  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SLOPE,
    CS_EST,
    CS_AMUL,
    CS_PPROD,
    CS_DIV,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] tx_fixed_na;
    logic             auto_tx;
    logic [CFG_W-1:0] anchor_low_na;
    logic [CFG_W-1:0] anchor_high_na;
    logic [CFG_W-1:0] rx_na;
    logic [CFG_W-1:0] cad_na;
    logic [CFG_W-1:0] idle_na;
    logic [CFG_W-1:0] sleep_na;
  } rsem_cfg_t;

  typedef struct packed {
    logic                load;
    logic                slope;
    logic                est;
    logic                amul;
    logic                pprod;
    logic [PP_IDX_W-1:0] pp_idx;
    logic                div;
    logic                finish;
  } rsem_cmd_t;

  typedef struct packed {
    logic pos;
  } rsem_sts_t;

endpackage

// ----- sv/rsem_regs.sv -----
// Configuration register file of the radio state energy meter.
// Depends on rsem_pkg for the register indexes and the register struct.
module rsem_regs import rsem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output rsem_cfg_t             cfg
);

  rsem_cfg_t cfg_r;
  rsem_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TX_FIXED:   cfg_nxt.tx_fixed_na    = cfg_wdata;
        REG_AUTO_TX:    cfg_nxt.auto_tx        = cfg_wdata[0];
        REG_ANCHOR_LOW: cfg_nxt.anchor_low_na  = cfg_wdata;
        REG_ANCHOR_HI:  cfg_nxt.anchor_high_na = cfg_wdata;
        REG_RX_CUR:     cfg_nxt.rx_na          = cfg_wdata;
        REG_CAD_CUR:    cfg_nxt.cad_na         = cfg_wdata;
        REG_IDLE_CUR:   cfg_nxt.idle_na        = cfg_wdata;
        REG_SLEEP_CUR:  cfg_nxt.sleep_na       = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_fixed_na    <= 29'd100000000;
      cfg_r.auto_tx        <= 1'b1;
      cfg_r.anchor_low_na  <= 29'd100000000;
      cfg_r.anchor_high_na <= 29'd120000000;
      cfg_r.rx_na          <= 29'd11000000;
      cfg_r.cad_na         <= 29'd11000000;
      cfg_r.idle_na        <= 29'd1000000;
      cfg_r.sleep_na       <= 29'd200;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/rsem_ctrl.sv -----
// Sequencing controller of the radio state energy meter.
// Depends on rsem_pkg for the state enum and the command and status structs.
module rsem_ctrl import rsem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rsem_sts_t sts,
  output rsem_cmd_t cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CS_SLOPE;
        end
      end
      CS_SLOPE: begin
        cmd.slope = 1'b1;
        state_nxt = sts.pos ? CS_EST : CS_DONE;
      end
      CS_EST: begin
        cmd.est   = 1'b1;
        state_nxt = CS_AMUL;
      end
      CS_AMUL: begin
        cmd.amul  = 1'b1;
        step_nxt  = '0;
        state_nxt = CS_PPROD;
      end
      CS_PPROD: begin
        cmd.pprod  = 1'b1;
        cmd.pp_idx = step_r[PP_IDX_W-1:0];
        if (step_r == STEP_W'(PP_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = CS_DIV;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      CS_DIV: begin
        cmd.div = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = CS_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      CS_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

// ----- sv/rsem_dp.sv -----
// Datapath of the radio state energy meter: current estimate, shared limb
// multiplier, radix-16 divider by one nanojoule and the energy registers. Uses rsem_pkg.
module rsem_dp import rsem_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsem_cmd_t                  cmd,
  output rsem_sts_t                  sts,
  input  rsem_cfg_t                  cfg,
  input  logic [TIME_BITS-1:0]       in_timestamp_us,
  input  logic [RSTATE_W-1:0]        in_new_state,
  input  logic signed [PWR_W-1:0]    in_tx_power_dbm,
  input  logic [VOLT_W-1:0]          in_supply_voltage_mv,
  output logic [NRG_W-1:0]           out_total_energy_nj,
  output logic [NRG_W-1:0]           out_interval_energy_nj
);

  // Architectural state.
  logic [TIME_BITS-1:0]     last_time_r;
  logic [RSTATE_W-1:0]      held_state_r;
  logic signed [PWR_W-1:0]  held_power_r;
  logic [NRG_W-1:0]         total_r;
  logic [REM_W-1:0]         remainder_r;

  // Per-event working registers.
  logic [TIME_BITS-1:0]     dt_r;
  logic                     pos_r;
  logic [RSTATE_W-1:0]      next_state_r;
  logic signed [PWR_W-1:0]  next_power_r;
  logic [VOLT_W-1:0]        volt_r;
  logic [SLOPE_W-1:0]       slope_mag_r;
  logic                     slope_neg_r;
  logic signed [4:0]        off_r;
  logic [CUR_W-1:0]         current_r;
  logic [A_W-1:0]           a_r;
  logic [ACC_W-1:0]         acc_r;
  logic [REM_W-1:0]         div_rem_r;
  logic [NRG_W-1:0]         out_total_r;
  logic [NRG_W-1:0]         out_interval_r;

  logic signed [CFG_W:0]         diff;
  logic [CFG_W-1:0]              diff_mag;
  logic [CFG_W+31:0]             recip_prod;
  logic signed [PWR_W-1:0]       pwr_cl;
  logic signed [PWR_W-1:0]       off_full;
  logic [3:0]                    off_mag;
  logic [CUR_W-1:0]              est_prod;
  logic                          est_neg;
  logic [CUR_W+1:0]              est_sum;
  logic [CUR_W-1:0]              est_cur;
  logic [CUR_W-1:0]              state_cur;
  logic [NRG_W-1:0]              dt64;
  logic [LIMB_W-1:0]             a_limb;
  logic [LIMB_W-1:0]             d_limb;
  logic [2*LIMB_W-1:0]           pp;
  logic [ACC_W-1:0]              pp_shifted;
  logic [REM_W+DIGIT_W-1:0]      div_x;
  logic [REM_W+DIGIT_W-1:0]      div_left;
  logic [DIGIT_W-1:0]            digit;
  logic [NRG_W-1:0]              quot_lo;
  logic                          quot_ovf;

  assign sts.pos                = pos_r;
  assign out_total_energy_nj    = out_total_r;
  assign out_interval_energy_nj = out_interval_r;

  // Slope magnitude of the transmit current line and clamped power offset.
  always_comb begin
    diff       = $signed({1'b0, cfg.anchor_high_na}) - $signed({1'b0, cfg.anchor_low_na});
    diff_mag   = diff[CFG_W] ? CFG_W'(-diff) : diff[CFG_W-1:0];
    recip_prod = (CFG_W+32)'(diff_mag) * (CFG_W+32)'(DIV6_RECIP);
    if (held_power_r < PWR_MIN) begin
      pwr_cl = PWR_MIN;
    end else if (held_power_r > PWR_MAX) begin
      pwr_cl = PWR_MAX;
    end else begin
      pwr_cl = held_power_r;
    end
    off_full = pwr_cl - PWR_ANCHOR;
  end

  // Linear estimate through the anchors, floored at zero.
  always_comb begin
    off_mag  = off_r[4] ? 4'(-off_r) : off_r[3:0];
    est_prod = CUR_W'(slope_mag_r) * CUR_W'(off_mag);
    est_neg  = slope_neg_r ^ off_r[4];
    if (est_neg) begin
      est_sum = (CUR_W+2)'(cfg.anchor_low_na) - (CUR_W+2)'(est_prod);
    end else begin
      est_sum = (CUR_W+2)'(cfg.anchor_low_na) + (CUR_W+2)'(est_prod);
    end
    est_cur = est_sum[CUR_W+1] ? '0 : est_sum[CUR_W-1:0];
    unique case (held_state_r)
      RS_TX:    state_cur = cfg.auto_tx ? est_cur : CUR_W'(cfg.tx_fixed_na);
      RS_RX:    state_cur = CUR_W'(cfg.rx_na);
      RS_CAD:   state_cur = CUR_W'(cfg.cad_na);
      RS_SLEEP: state_cur = CUR_W'(cfg.sleep_na);
      default:  state_cur = CUR_W'(cfg.idle_na);
    endcase
  end

  // One 32x32 partial product of charge = (current x voltage) x elapsed time.
  always_comb begin
    dt64   = NRG_W'(dt_r);
    a_limb = cmd.pp_idx[1] ? LIMB_W'(a_r[A_W-1:LIMB_W]) : a_r[LIMB_W-1:0];
    d_limb = cmd.pp_idx[0] ? dt64[NRG_W-1:LIMB_W] : dt64[LIMB_W-1:0];
    pp     = (2*LIMB_W)'(a_limb) * (2*LIMB_W)'(d_limb);
    unique case (cmd.pp_idx)
      2'b00:        pp_shifted = ACC_W'(pp);
      2'b01, 2'b10: pp_shifted = {32'b0, pp, 32'b0};
      2'b11:        pp_shifted = {pp, 64'b0};
      default:      pp_shifted = '0;
    endcase
  end

  // One radix-16 quotient digit of the division by one nanojoule.
  always_comb begin
    div_x = {div_rem_r, acc_r[ACC_W-1:ACC_W-DIGIT_W]};
    digit = '0;
    for (int k = 1; k < 2**DIGIT_W; k++) begin
      if (div_x >= NJ_MULT[k]) begin
        digit = DIGIT_W'(k);
      end
    end
    div_left = div_x - NJ_MULT[digit];
    quot_lo  = acc_r[NRG_W-1:0];
    quot_ovf = |acc_r[ACC_W-1:NRG_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      held_state_r <= RS_IDLE;
      held_power_r <= PWR_ANCHOR;
      total_r      <= '0;
      remainder_r  <= '0;
    end else begin
      if (cmd.load) begin
        last_time_r <= in_timestamp_us;
      end
      if (cmd.finish) begin
        held_state_r <= next_state_r;
        held_power_r <= next_power_r;
        if (pos_r) begin
          total_r     <= total_r + quot_lo;
          remainder_r <= div_rem_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r         <= in_timestamp_us - last_time_r;
      pos_r        <= in_timestamp_us > last_time_r;
      next_state_r <= in_new_state;
      next_power_r <= in_tx_power_dbm;
      volt_r       <= in_supply_voltage_mv;
      acc_r        <= ACC_W'(remainder_r);
      div_rem_r    <= '0;
    end
    if (cmd.slope) begin
      slope_mag_r <= recip_prod[DIV6_SHIFT +: SLOPE_W];
      slope_neg_r <= diff[CFG_W];
      off_r       <= off_full[4:0];
    end
    if (cmd.est) begin
      current_r <= state_cur;
    end
    if (cmd.amul) begin
      a_r <= A_W'(current_r) * A_W'(volt_r);
    end
    if (cmd.pprod) begin
      acc_r <= acc_r + pp_shifted;
    end
    if (cmd.div) begin
      acc_r     <= {acc_r[ACC_W-DIGIT_W-1:0], digit};
      div_rem_r <= div_left[REM_W-1:0];
    end
    if (cmd.finish) begin
      if (pos_r) begin
        out_total_r    <= total_r + quot_lo;
        out_interval_r <= quot_ovf ? '1 : quot_lo;
      end else begin
        out_total_r    <= total_r;
        out_interval_r <= '0;
      end
    end
  end

endmodule

// ----- sv/radio_state_energy_meter.sv -----
// Top level of the radio state energy meter; uses rsem_pkg, rsem_regs, rsem_ctrl, rsem_dp.
// A result is valid once the work on its word is done; when the interval is not positive
// the arithmetic is skipped. The next word is taken only after the last result is registered.
// The work takes 4 passes of the shared 32x32 multiplier and 32 radix-16 divider steps.
// Reset (rst_n low, synchronous) restores the registers, clears the total and remainder,
// sets the held state to idle at 14 dBm and time zero, and empties the output register.
module radio_state_energy_meter import rsem_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TIME_BITS-1:0]     in_timestamp_us,
  input  logic [RSTATE_W-1:0]      in_new_state,
  input  logic signed [PWR_W-1:0]  in_tx_power_dbm,
  input  logic [VOLT_W-1:0]        in_supply_voltage_mv,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NRG_W-1:0]         out_total_energy_nj,
  output logic [NRG_W-1:0]         out_interval_energy_nj,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  // The register file is always ready. Writes are expected only while the
  // meter is idle, so the datapath reads the registers directly.
  rsem_cfg_t cfg;
  rsem_cmd_t cmd;
  rsem_sts_t sts;

  rsem_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The controller takes one word at a time. It steps the datapath through
  // the slope, estimate, current times voltage, four partial products and
  // thirty-two quotient digits. A finished result sits in the output register
  // until it is taken, while the next word is already accepted and worked on.
  // When the timestamp does not advance, the arithmetic is skipped and a zero
  // interval is reported.
  rsem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath charges the interval at the current of the state held
  // until now. The charge is an exact integer in 1e-18 J. It is added to
  // the kept sub-nanojoule remainder and divided by 1e9. The whole
  // nanojoules go to the wrapping total, and the interval output saturates
  // when the quotient does not fit in 64 bits.
  rsem_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg                    (cfg),
    .in_timestamp_us        (in_timestamp_us),
    .in_new_state           (in_new_state),
    .in_tx_power_dbm        (in_tx_power_dbm),
    .in_supply_voltage_mv   (in_supply_voltage_mv),
    .out_total_energy_nj    (out_total_energy_nj),
    .out_interval_energy_nj (out_interval_energy_nj)
  );

endmodule

// ----- sv/rsem_checker.sv -----
// Port-level checker of the radio state energy meter and its bind statement.
// Depends on radio_state_energy_meter_assert.svh for the assertion macros.
`include "radio_state_energy_meter_assert.svh"

module rsem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_total_energy_nj,
  input logic [63:0] out_interval_energy_nj
);

  // A result that is not taken keeps its word.
  `RSEM_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_total_energy_nj) && $stable(out_interval_energy_nj),
    "stalled result changed")

  // Only one word is in the meter at a time.
  `RSEM_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input still ready right after an accept")

  // Ready drops only because a word was taken.
  `RSEM_ASSERT_IMP(a_ready_fall, $fell(in_ready), $past(in_valid),
    "input ready fell without an accept")

  // A new result appears only at the end of the work on a word.
  `RSEM_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(!in_ready),
    "result appeared while the meter was idle")

endmodule

bind radio_state_energy_meter rsem_checker u_rsem_checker (.*);
